// File: hdl/dkn_pkg.sv
// Shared constants, codes and types of the descriptor k-nearest-neighbor selector.
// Used by dkn_list and descriptor_knn_selector; depends on nothing else.
`timescale 1ns / 1ps

package dkn_pkg;

	localparam int MAX_NEIGHBORS = 16;
	localparam int MAX_DIMENSION = 128;

	localparam int NBR_IDX_W = $clog2(MAX_NEIGHBORS);
	localparam int CNT_W     = $clog2(MAX_NEIGHBORS + 1);
	localparam int POS_W     = $clog2(MAX_DIMENSION);
	localparam int LEN_W     = 8;
	localparam int K_W       = 5;
	localparam int ELEM_W    = 8;
	localparam int ID_W      = 16;
	localparam int DIST_W    = 23;
	localparam int SQ_W      = 2 * ELEM_W;
	localparam int RANK_W    = 4;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	localparam logic [1:0] ACT_CLEAR     = 2'd0;
	localparam logic [1:0] ACT_QUERY     = 2'd1;
	localparam logic [1:0] ACT_CANDIDATE = 2'd2;
	localparam logic [1:0] ACT_READ      = 2'd3;

	localparam logic [1:0] CFG_NEIGHBORS_KEPT    = 2'd0;
	localparam logic [1:0] CFG_DESCRIPTOR_LENGTH = 2'd1;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_ENTRY   = 1'b1;

	// Command from the distance datapath to the neighbor list.
	typedef struct packed {
		logic              clear;
		logic              insert;
		logic              read;
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] dist_sq;
	} list_cmd_t;

endpackage

// File: hdl/dkn_list.sv
// Sorted neighbor list with a one-entry-per-cycle insertion sequencer and readout.
// Depends on dkn_pkg; instantiated by descriptor_knn_selector.
`timescale 1ns / 1ps

module dkn_list (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dkn_pkg::list_cmd_t                  cmd,
	input  logic [dkn_pkg::K_W-1:0]             k_eff,
	output logic                                list_busy,
	output logic                                strobe,
	output logic                                kind,
	output logic                                inserted,
	output logic [dkn_pkg::RANK_W-1:0]          rank,
	output logic [dkn_pkg::ID_W-1:0]            neighbor_id,
	output logic [dkn_pkg::DIST_W-1:0]          distance,
	output logic [dkn_pkg::CNT_W-1:0]           list_count,
	output logic                                last
);

	typedef enum logic [3:0] {
		L_IDLE  = 4'b0001,
		L_CHK   = 4'b0010,
		L_SHIFT = 4'b0100,
		L_READ  = 4'b1000
	} lstate_t;

	lstate_t state_q;

	logic [dkn_pkg::ID_W-1:0]      ids_q   [dkn_pkg::MAX_NEIGHBORS];
	logic [dkn_pkg::DIST_W-1:0]    dists_q [dkn_pkg::MAX_NEIGHBORS];
	logic [dkn_pkg::CNT_W-1:0]     held_q;
	logic [dkn_pkg::NBR_IDX_W-1:0] idx_q;
	logic [dkn_pkg::ID_W-1:0]      cand_id_q;
	logic [dkn_pkg::DIST_W-1:0]    cand_dist_q;

	logic                          strobe_q;
	logic                          kind_q;
	logic                          inserted_q;
	logic [dkn_pkg::RANK_W-1:0]    rank_q;
	logic [dkn_pkg::ID_W-1:0]      id_out_q;
	logic [dkn_pkg::DIST_W-1:0]    dist_out_q;
	logic [dkn_pkg::CNT_W-1:0]     count_out_q;
	logic                          last_q;

	logic [dkn_pkg::CNT_W-1:0]     n_eff;
	logic [dkn_pkg::CNT_W-1:0]     n_minus1;
	logic [dkn_pkg::NBR_IDX_W-1:0] prev_idx;
	logic [dkn_pkg::NBR_IDX_W-1:0] rd_addr;
	logic [dkn_pkg::ID_W-1:0]      rd_id;
	logic [dkn_pkg::DIST_W-1:0]    rd_dist;
	logic                          read_last;

	// Entries held beyond a lowered k are cut off at the next insertion.
	assign n_eff    = (held_q > k_eff) ? k_eff : held_q;
	assign n_minus1 = n_eff - 1'b1;
	assign prev_idx = idx_q - 1'b1;
	assign read_last = ({1'b0, idx_q} + 1'b1) == held_q;

	// One shared read port; the address follows the sequencer step.
	always_comb begin
		case (state_q)
			L_CHK:   rd_addr = n_minus1[dkn_pkg::NBR_IDX_W-1:0];
			L_SHIFT: rd_addr = prev_idx;
			L_READ:  rd_addr = idx_q;
			default: rd_addr = idx_q;
		endcase
	end

	assign rd_id   = ids_q[rd_addr];
	assign rd_dist = dists_q[rd_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= L_IDLE;
			held_q   <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (cmd.clear) begin
						held_q <= '0;
					end else if (cmd.insert) begin
						state_q <= L_CHK;
					end else if (cmd.read && held_q != '0) begin
						idx_q   <= '0;
						state_q <= L_READ;
					end
				end
				L_CHK: begin
					if (n_eff == '0) begin
						held_q   <= dkn_pkg::CNT_W'(1);
						strobe_q <= 1'b1;
						state_q  <= L_IDLE;
					end else if (cand_dist_q >= rd_dist) begin
						strobe_q <= 1'b1;
						state_q  <= L_IDLE;
						if (n_eff >= k_eff) begin
							held_q <= n_eff;
						end else begin
							held_q <= n_eff + 1'b1;
						end
					end else begin
						state_q <= L_SHIFT;
						if (n_eff < k_eff) begin
							held_q <= n_eff + 1'b1;
							idx_q  <= n_eff[dkn_pkg::NBR_IDX_W-1:0];
						end else begin
							held_q <= n_eff;
							idx_q  <= n_minus1[dkn_pkg::NBR_IDX_W-1:0];
						end
					end
				end
				L_SHIFT: begin
					if (idx_q != '0 && rd_dist > cand_dist_q) begin
						idx_q <= prev_idx;
					end else begin
						strobe_q <= 1'b1;
						state_q  <= L_IDLE;
					end
				end
				L_READ: begin
					strobe_q <= 1'b1;
					idx_q    <= idx_q + 1'b1;
					if (read_last) begin
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	// List storage and result payload; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (cmd.insert) begin
					cand_id_q   <= cmd.id;
					cand_dist_q <= cmd.dist_sq;
				end
			end
			L_CHK: begin
				kind_q     <= dkn_pkg::KIND_VERDICT;
				id_out_q   <= cand_id_q;
				dist_out_q <= cand_dist_q;
				last_q     <= 1'b1;
				rank_q     <= '0;
				if (n_eff == '0) begin
					ids_q[0]    <= cand_id_q;
					dists_q[0]  <= cand_dist_q;
					inserted_q  <= 1'b1;
					count_out_q <= dkn_pkg::CNT_W'(1);
				end else if (cand_dist_q >= rd_dist) begin
					if (n_eff >= k_eff) begin
						inserted_q  <= 1'b0;
						count_out_q <= n_eff;
					end else begin
						ids_q[n_eff[dkn_pkg::NBR_IDX_W-1:0]]   <= cand_id_q;
						dists_q[n_eff[dkn_pkg::NBR_IDX_W-1:0]] <= cand_dist_q;
						inserted_q  <= 1'b1;
						rank_q      <= dkn_pkg::RANK_W'(n_eff);
						count_out_q <= n_eff + 1'b1;
					end
				end
			end
			L_SHIFT: begin
				if (idx_q != '0 && rd_dist > cand_dist_q) begin
					ids_q[idx_q]   <= rd_id;
					dists_q[idx_q] <= rd_dist;
				end else begin
					ids_q[idx_q]   <= cand_id_q;
					dists_q[idx_q] <= cand_dist_q;
					inserted_q     <= 1'b1;
					rank_q         <= dkn_pkg::RANK_W'(idx_q);
					count_out_q    <= held_q;
				end
			end
			L_READ: begin
				kind_q      <= dkn_pkg::KIND_ENTRY;
				inserted_q  <= 1'b0;
				rank_q      <= dkn_pkg::RANK_W'(idx_q);
				id_out_q    <= rd_id;
				dist_out_q  <= rd_dist;
				count_out_q <= held_q;
				last_q      <= read_last;
			end
			default: begin
				last_q <= last_q;
			end
		endcase
	end

	assign list_busy   = (state_q != L_IDLE);
	assign strobe      = strobe_q;
	assign kind        = kind_q;
	assign inserted    = inserted_q;
	assign rank        = rank_q;
	assign neighbor_id = id_out_q;
	assign distance    = dist_out_q;
	assign list_count  = count_out_q;
	assign last        = last_q;

	// A new command may only arrive while the sequencer is idle.
	a_cmd_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.insert || cmd.read || cmd.clear) |-> (state_q == L_IDLE))
		else $error("list command while sequencer busy");

	// The insertion slot always lies inside the held part of the list.
	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == L_SHIFT) |-> ({1'b0, idx_q} < held_q))
		else $error("insertion index beyond held entries");

	// Held entries never exceed the list capacity.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= dkn_pkg::CNT_W'(dkn_pkg::MAX_NEIGHBORS))
		else $error("entry count above capacity");

	// A verdict is always the single and final result of its candidate.
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && kind_q == dkn_pkg::KIND_VERDICT) |-> last_q)
		else $error("verdict not marked last");

endmodule

// File: hdl/descriptor_knn_selector.sv
// Top level of the descriptor k-nearest-neighbor selector: configuration, query store
// and the squared-distance accumulator. Depends on dkn_pkg and dkn_list.
// Clear and query elements take effect at the accepting edge; busy stays low.
// A candidate element is read on accept, then busy stays high to square and accumulate;
// a last element then adds the list insertion, one list entry moved per cycle.
// A read emits one entry per cycle and keeps busy high until the last held entry is out.
// Results are registered outputs; the receiver cannot stall them.
// Asynchronous reset: list empty, position and sum zero, k = 2, length = 128.
`timescale 1ns / 1ps

module descriptor_knn_selector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic [dkn_pkg::ELEM_W-1:0]    element_value,
	input  logic [dkn_pkg::ID_W-1:0]      candidate_id,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [dkn_pkg::LEN_W-1:0]     cfg_data,
	output logic                          strobe,
	output logic                          kind,
	output logic                          inserted,
	output logic [dkn_pkg::RANK_W-1:0]    rank,
	output logic [dkn_pkg::ID_W-1:0]      neighbor_id,
	output logic [dkn_pkg::DIST_W-1:0]    distance,
	output logic [dkn_pkg::CNT_W-1:0]     list_count,
	output logic                          last
);

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_MUL  = 3'b010,
		T_ACC  = 3'b100
	} tstate_t;

	tstate_t state_q;

	logic [dkn_pkg::K_W-1:0]    k_q;
	logic [dkn_pkg::LEN_W-1:0]  len_q;
	logic [dkn_pkg::POS_W-1:0]  pos_q;
	logic [dkn_pkg::DIST_W-1:0] acc_q;
	logic [dkn_pkg::ELEM_W-1:0] qmem [dkn_pkg::MAX_DIMENSION];
	logic [dkn_pkg::ELEM_W-1:0] q_rd_q;
	logic [dkn_pkg::ELEM_W-1:0] val_q;
	logic [dkn_pkg::ID_W-1:0]   id_q;
	logic                       last_elem_q;
	logic [dkn_pkg::SQ_W-1:0]   sq_q;

	logic                       accept;
	logic                       list_busy;
	logic [dkn_pkg::K_W-1:0]    k_eff;
	logic [dkn_pkg::LEN_W-1:0]  len_eff;
	logic [dkn_pkg::POS_W-1:0]  pos_eff;
	logic                       pos_last;
	logic [dkn_pkg::ELEM_W-1:0] diff;
	logic [dkn_pkg::DIST_W:0]   sum;
	logic [dkn_pkg::DIST_W-1:0] acc_next;
	dkn_pkg::list_cmd_t         cmd;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != T_IDLE) || list_busy;
	assign accept    = start && !busy;

	always_comb begin
		if (k_q == '0) begin
			k_eff = dkn_pkg::K_W'(1);
		end else if (k_q > dkn_pkg::K_W'(dkn_pkg::MAX_NEIGHBORS)) begin
			k_eff = dkn_pkg::K_W'(dkn_pkg::MAX_NEIGHBORS);
		end else begin
			k_eff = k_q;
		end
		if (len_q == '0) begin
			len_eff = dkn_pkg::LEN_W'(1);
		end else if (len_q > dkn_pkg::LEN_W'(dkn_pkg::MAX_DIMENSION)) begin
			len_eff = dkn_pkg::LEN_W'(dkn_pkg::MAX_DIMENSION);
		end else begin
			len_eff = len_q;
		end
	end

	// A position left beyond a lowered length counts as the last one.
	always_comb begin
		logic [dkn_pkg::LEN_W-1:0] len_m1;
		len_m1 = len_eff - 1'b1;
		if (dkn_pkg::LEN_W'(pos_q) >= len_eff) begin
			pos_eff = len_m1[dkn_pkg::POS_W-1:0];
		end else begin
			pos_eff = pos_q;
		end
	end

	assign pos_last = (dkn_pkg::LEN_W'(pos_eff) + 1'b1) >= len_eff;

	assign diff     = (q_rd_q > val_q) ? (q_rd_q - val_q) : (val_q - q_rd_q);
	assign sum      = {1'b0, acc_q} + (dkn_pkg::DIST_W + 1)'(sq_q);
	assign acc_next = sum[dkn_pkg::DIST_W] ? dkn_pkg::DIST_MAX : sum[dkn_pkg::DIST_W-1:0];

	always_comb begin
		cmd         = '0;
		cmd.clear   = accept && (action == dkn_pkg::ACT_CLEAR);
		cmd.read    = accept && (action == dkn_pkg::ACT_READ);
		cmd.insert  = (state_q == T_ACC) && last_elem_q;
		cmd.id      = id_q;
		cmd.dist_sq = acc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= dkn_pkg::K_W'(2);
			len_q <= dkn_pkg::LEN_W'(dkn_pkg::MAX_DIMENSION);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dkn_pkg::CFG_NEIGHBORS_KEPT:    k_q   <= cfg_data[dkn_pkg::K_W-1:0];
				dkn_pkg::CFG_DESCRIPTOR_LENGTH: len_q <= cfg_data;
				default:                        len_q <= len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			pos_q   <= '0;
			acc_q   <= '0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						case (action)
							dkn_pkg::ACT_CLEAR: begin
								pos_q <= '0;
								acc_q <= '0;
							end
							dkn_pkg::ACT_QUERY: begin
								pos_q <= pos_last ? '0 : pos_eff + 1'b1;
							end
							dkn_pkg::ACT_CANDIDATE: begin
								pos_q   <= pos_last ? '0 : pos_eff + 1'b1;
								state_q <= T_MUL;
							end
							default: begin
								pos_q <= pos_q;
							end
						endcase
					end
				end
				T_MUL: begin
					state_q <= T_ACC;
				end
				T_ACC: begin
					acc_q   <= last_elem_q ? '0 : acc_next;
					state_q <= T_IDLE;
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// Query store with a registered read port, plus the candidate datapath registers.
	always_ff @(posedge clk) begin
		if (accept && action == dkn_pkg::ACT_QUERY) begin
			qmem[pos_eff] <= element_value;
		end
		if (accept) begin
			q_rd_q      <= qmem[pos_eff];
			val_q       <= element_value;
			id_q        <= candidate_id;
			last_elem_q <= pos_last;
		end
		if (state_q == T_MUL) begin
			sq_q <= diff * diff;
		end
	end

	dkn_list u_list (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.k_eff       (k_eff),
		.list_busy   (list_busy),
		.strobe      (strobe),
		.kind        (kind),
		.inserted    (inserted),
		.rank        (rank),
		.neighbor_id (neighbor_id),
		.distance    (distance),
		.list_count  (list_count),
		.last        (last)
	);

	// The list sequencer and the accumulator never run at the same time.
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != T_IDLE) |-> !list_busy)
		else $error("accumulator active during list work");

	// Every last candidate element hands exactly one insertion to the list.
	a_insert_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_ACC && last_elem_q) |=> (list_busy && acc_q == '0))
		else $error("insertion not started after last element");

	// The accumulation pair always follows an accepted candidate element.
	a_mul_then_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_MUL) |=> (state_q == T_ACC))
		else $error("square step not followed by accumulate");

endmodule
